>>> rtl/concatenated_integer_digit_top_defines.svh
// Assertion macros for the digit lookup block
`ifndef CONCATENATED_INTEGER_DIGIT_TOP_DEFINES_SVH
`define CONCATENATED_INTEGER_DIGIT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante
`define CID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cid assertion failed");
// Check that cons holds after ante, at the delay given by dly
`define CID_ASSERT_DLY(label, clk, rst_n, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error("cid assertion failed");
`else
`define CID_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CID_ASSERT_DLY(label, clk, rst_n, ante, dly, cons)
`endif
`endif

>>> rtl/cid_pkg.sv
`timescale 1ns / 1ps
package cid_pkg;

  localparam int POS_W    = 60;  // position and number width
  localparam int DIGIT_W  = 4;   // result digit width
  localparam int CNT_W    = 64;  // width of the digit count constants
  localparam int DIV_STEP = 4;   // quotient bits per divider stage
  localparam int BCD_STEP = 4;   // binary bits per BCD conversion stage

  // Power of ten, evaluated at elaboration
  function automatic logic [CNT_W-1:0] pow10(input int e);
    logic [CNT_W-1:0] p;
    p = CNT_W'(1);
    for (int i = 0; i < e; i++) begin
      p = p * CNT_W'(10);
    end
    return p;
  endfunction

  // Total digits taken by all numbers of 1..d digits, evaluated at elaboration
  function automatic logic [CNT_W-1:0] cum_count(input int d);
    logic [CNT_W-1:0] p;
    logic [CNT_W-1:0] s;
    p = CNT_W'(1);
    s = '0;
    for (int j = 1; j <= d; j++) begin
      s = s + CNT_W'(9) * p * CNT_W'(j);
      p = p * CNT_W'(10);
    end
    return s;
  endfunction

endpackage

>>> rtl/cid_div_pipe.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: a wide dividend over a narrow divisor,
// a few quotient bits per stage, with a tag carried alongside.
module cid_div_pipe #(
  parameter int DVS_W = 5,
  parameter int TAG_W = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic [cid_pkg::POS_W-1:0] in_dividend,
  input  logic [DVS_W-1:0]          in_divisor,
  input  logic [TAG_W-1:0]          in_tag,
  output logic                      out_vld,
  output logic [cid_pkg::POS_W-1:0] out_quot,
  output logic [DVS_W-1:0]          out_rem,
  output logic [TAG_W-1:0]          out_tag
);

  localparam int POS_W  = cid_pkg::POS_W;
  localparam int STEP   = cid_pkg::DIV_STEP;
  localparam int STAGES = POS_W / STEP;

  logic                 vld_r [STAGES];
  logic [POS_W-1:0]     acc_r [STAGES];
  logic [DVS_W-1:0]     rem_r [STAGES];
  logic [DVS_W-1:0]     dvs_r [STAGES];
  logic [TAG_W-1:0]     tag_r [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stg
    logic             vld_in;
    logic [POS_W-1:0] acc_in;
    logic [DVS_W-1:0] rem_in;
    logic [DVS_W-1:0] dvs_in;
    logic [TAG_W-1:0] tag_in;
    logic [POS_W-1:0] acc_nxt;
    logic [DVS_W-1:0] rem_nxt;

    // Take the operands from the port or from the stage ahead
    if (s == 0) begin : g_first
      assign vld_in = in_vld;
      assign acc_in = in_dividend;
      assign rem_in = '0;
      assign dvs_in = in_divisor;
      assign tag_in = in_tag;
    end else begin : g_next
      assign vld_in = vld_r[s-1];
      assign acc_in = acc_r[s-1];
      assign rem_in = rem_r[s-1];
      assign dvs_in = dvs_r[s-1];
      assign tag_in = tag_r[s-1];
    end

    // Shift in dividend bits, subtract where the divisor fits
    always_comb begin
      logic [DVS_W:0] t;
      rem_nxt = rem_in;
      acc_nxt = acc_in;
      for (int i = 0; i < STEP; i++) begin
        t = {rem_nxt, acc_nxt[POS_W-1]};
        if (t >= {1'b0, dvs_in}) begin
          rem_nxt = DVS_W'(t - {1'b0, dvs_in});
          acc_nxt = {acc_nxt[POS_W-2:0], 1'b1};
        end else begin
          rem_nxt = t[DVS_W-1:0];
          acc_nxt = {acc_nxt[POS_W-2:0], 1'b0};
        end
      end
    end

    // Advance the valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    // Advance the payload
    always_ff @(posedge clk) begin
      acc_r[s] <= acc_nxt;
      rem_r[s] <= rem_nxt;
      dvs_r[s] <= dvs_in;
      tag_r[s] <= tag_in;
    end
  end

  assign out_vld  = vld_r[STAGES-1];
  assign out_quot = acc_r[STAGES-1];
  assign out_rem  = rem_r[STAGES-1];
  assign out_tag  = tag_r[STAGES-1];

endmodule

>>> rtl/cid_bcd_pipe.sv
`timescale 1ns / 1ps
// Pipelined binary to BCD conversion (shift and add three),
// a few binary bits per stage, with a tag carried alongside.
module cid_bcd_pipe #(
  parameter int NDIG  = 18,
  parameter int TAG_W = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic [cid_pkg::POS_W-1:0] in_bin,
  input  logic [TAG_W-1:0]          in_tag,
  output logic                      out_vld,
  output logic [NDIG*4-1:0]         out_bcd,
  output logic [TAG_W-1:0]          out_tag
);

  localparam int POS_W  = cid_pkg::POS_W;
  localparam int STEP   = cid_pkg::BCD_STEP;
  localparam int STAGES = POS_W / STEP;
  localparam int BW     = NDIG * 4;

  logic             vld_r [STAGES];
  logic [POS_W-1:0] bin_r [STAGES];
  logic [BW-1:0]    bcd_r [STAGES];
  logic [TAG_W-1:0] tag_r [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stg
    logic             vld_in;
    logic [POS_W-1:0] bin_in;
    logic [BW-1:0]    bcd_in;
    logic [TAG_W-1:0] tag_in;
    logic [POS_W-1:0] bin_nxt;
    logic [BW-1:0]    bcd_nxt;

    // Take the operands from the port or from the stage ahead
    if (s == 0) begin : g_first
      assign vld_in = in_vld;
      assign bin_in = in_bin;
      assign bcd_in = '0;
      assign tag_in = in_tag;
    end else begin : g_next
      assign vld_in = vld_r[s-1];
      assign bin_in = bin_r[s-1];
      assign bcd_in = bcd_r[s-1];
      assign tag_in = tag_r[s-1];
    end

    // Correct every digit of five or more, then shift in the next bit
    always_comb begin
      bin_nxt = bin_in;
      bcd_nxt = bcd_in;
      for (int i = 0; i < STEP; i++) begin
        for (int dg = 0; dg < NDIG; dg++) begin
          if (bcd_nxt[dg*4 +: 4] >= 4'd5) begin
            bcd_nxt[dg*4 +: 4] = bcd_nxt[dg*4 +: 4] + 4'd3;
          end
        end
        bcd_nxt = {bcd_nxt[BW-2:0], bin_nxt[POS_W-1]};
        bin_nxt = {bin_nxt[POS_W-2:0], 1'b0};
      end
    end

    // Advance the valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    // Advance the payload
    always_ff @(posedge clk) begin
      bin_r[s] <= bin_nxt;
      bcd_r[s] <= bcd_nxt;
      tag_r[s] <= tag_in;
    end
  end

  assign out_vld = vld_r[STAGES-1];
  assign out_bcd = bcd_r[STAGES-1];
  assign out_tag = tag_r[STAGES-1];

endmodule

>>> rtl/concatenated_integer_digit_top.sv
`timescale 1ns / 1ps
// Digit at a one-based position of the string 123456789101112...
// Throughput: one position per cycle while busy is low; the divider and the BCD converter are
// fully pipelined, one stage per four bits of the 60-bit number.
// Reset: synchronous, active low; clears all valid bits and holds busy high.
// Each result shows for one cycle with out_valid; the receiver cannot stall.
`include "concatenated_integer_digit_top_defines.svh"
module concatenated_integer_digit_top #(
  parameter int MAX_DIGIT_LENGTH = 18
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [cid_pkg::POS_W-1:0]   in_position,
  output logic                        out_valid,
  output logic [cid_pkg::DIGIT_W-1:0] out_digit
);

  localparam int POS_W      = cid_pkg::POS_W;
  localparam int CNT_W      = cid_pkg::CNT_W;
  localparam int DIGIT_W    = cid_pkg::DIGIT_W;
  localparam int MAXD       = MAX_DIGIT_LENGTH;
  localparam int LEN_W      = $clog2(MAXD + 1);
  localparam int IDX_W      = (MAXD > 1) ? $clog2(MAXD) : 1;
  localparam int TAG_W      = 1 + IDX_W;
  localparam int DIV_STAGES = POS_W / cid_pkg::DIV_STEP;
  localparam int BCD_STAGES = POS_W / cid_pkg::BCD_STEP;
  localparam int LATENCY    = 4 + DIV_STAGES + BCD_STAGES;

  // Constant tables per digit length
  logic [CNT_W-1:0] cum_tab  [MAXD];  // digits up to and including length g+1
  logic [CNT_W-1:0] prev_tab [MAXD];  // digits before length g+1
  logic [CNT_W-1:0] pow_tab  [MAXD];  // smallest number of length g+1
  logic [MAXD-1:0]  hit;

  for (genvar g = 0; g < MAXD; g++) begin : g_tab
    assign cum_tab[g]  = cid_pkg::cum_count(g + 1);
    assign prev_tab[g] = cid_pkg::cum_count(g);
    assign pow_tab[g]  = cid_pkg::pow10(g);
    assign hit[g]      = CNT_W'(in_position) <= cum_tab[g];
  end

  // Hold busy through reset
  logic busy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end
  assign busy = busy_r;

  logic accept;
  assign accept = start && !busy_r;

  // Stage A: find the digit length of the number holding the position
  logic             a_ok_nxt;
  logic [IDX_W-1:0] a_lm1_nxt;
  always_comb begin
    logic found;
    found     = 1'b0;
    a_lm1_nxt = '0;
    for (int i = MAXD - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found     = 1'b1;
        a_lm1_nxt = IDX_W'(i);
      end
    end
    a_ok_nxt = found && (in_position != '0);
  end

  logic             a_vld_r;
  logic             a_ok_r;
  logic [IDX_W-1:0] a_lm1_r;
  logic [POS_W-1:0] a_pos_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= accept;
    end
  end
  always_ff @(posedge clk) begin
    a_ok_r  <= a_ok_nxt;
    a_lm1_r <= a_lm1_nxt;
    a_pos_r <= in_position;
  end

  // Stage B: zero-based digit offset within the numbers of that length
  logic [POS_W-1:0] b_m_nxt;
  assign b_m_nxt = a_pos_r - prev_tab[a_lm1_r][POS_W-1:0] - POS_W'(1);

  logic             b_vld_r;
  logic             b_ok_r;
  logic [IDX_W-1:0] b_lm1_r;
  logic [POS_W-1:0] b_m_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    b_ok_r  <= a_ok_r;
    b_lm1_r <= a_lm1_r;
    b_m_r   <= b_m_nxt;
  end

  // Divide the offset by the digit length
  logic [LEN_W-1:0] b_len;
  assign b_len = LEN_W'(b_lm1_r) + LEN_W'(1);

  logic             div_vld;
  logic [POS_W-1:0] div_quot;
  logic [LEN_W-1:0] div_rem;
  logic [TAG_W-1:0] div_tag;

  cid_div_pipe #(
    .DVS_W (LEN_W),
    .TAG_W (TAG_W)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (b_vld_r),
    .in_dividend (b_m_r),
    .in_divisor  (b_len),
    .in_tag      ({b_ok_r, b_lm1_r}),
    .out_vld     (div_vld),
    .out_quot    (div_quot),
    .out_rem     (div_rem),
    .out_tag     (div_tag)
  );

  // Stage C: form the number and the digit place counted from the right
  logic             d_ok;
  logic [IDX_W-1:0] d_lm1;
  assign d_ok  = div_tag[TAG_W-1];
  assign d_lm1 = div_tag[IDX_W-1:0];

  logic             c_vld_r;
  logic             c_ok_r;
  logic [IDX_W-1:0] c_e_r;
  logic [POS_W-1:0] c_num_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= div_vld;
    end
  end
  always_ff @(posedge clk) begin
    c_ok_r  <= d_ok;
    c_e_r   <= d_lm1 - IDX_W'(div_rem);
    c_num_r <= pow_tab[d_lm1][POS_W-1:0] + div_quot;
  end

  // Convert the number to decimal digits
  logic              bcd_vld;
  logic [MAXD*4-1:0] bcd_val;
  logic [TAG_W-1:0]  bcd_tag;

  cid_bcd_pipe #(
    .NDIG  (MAXD),
    .TAG_W (TAG_W)
  ) u_bcd (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (c_vld_r),
    .in_bin  (c_num_r),
    .in_tag  ({c_ok_r, c_e_r}),
    .out_vld (bcd_vld),
    .out_bcd (bcd_val),
    .out_tag (bcd_tag)
  );

  logic [3:0] bcd_dig [MAXD];
  for (genvar g = 0; g < MAXD; g++) begin : g_dig
    assign bcd_dig[g] = bcd_val[g*4 +: 4];
  end

  // Output stage: pick the digit, drop it to zero for positions out of range
  logic [DIGIT_W-1:0] out_digit_nxt;
  assign out_digit_nxt = bcd_tag[TAG_W-1] ? DIGIT_W'(bcd_dig[bcd_tag[IDX_W-1:0]]) : '0;

  logic               out_valid_r;
  logic [DIGIT_W-1:0] out_digit_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= bcd_vld;
    end
  end
  always_ff @(posedge clk) begin
    out_digit_r <= out_digit_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_digit = out_digit_r;

  // Every transfer in gives a strobe on out_valid once it has passed the whole pipeline
  `CID_ASSERT_DLY(a_latency, clk, rst_n, start && !busy, LATENCY, out_valid)
  // Position zero yields digit zero
  `CID_ASSERT_DLY(a_zero_pos, clk, rst_n, start && !busy && in_position == '0, LATENCY, out_valid && out_digit == '0)
  // The first position holds the digit one
  `CID_ASSERT_DLY(a_first_pos, clk, rst_n, start && !busy && in_position == 1, LATENCY, out_valid && out_digit == 1)
  // A delivered digit is always decimal
  `CID_ASSERT_NOW(a_decimal, clk, rst_n, out_valid, out_digit <= 4'd9)

endmodule
